FILE: design/crc_framer_with_error_injection_assert.svh
// assertion macros shared by the checker
`ifndef CRC_FRAMER_WITH_ERROR_INJECTION_ASSERT_SVH
`define CRC_FRAMER_WITH_ERROR_INJECTION_ASSERT_SVH

// same-cycle implication, held off during reset
`define CFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfb assertion failed");

// next-cycle implication, held off during reset
`define CFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfb assertion failed");

`endif

FILE: design/cfb_pkg.sv
package cfb_pkg;

  localparam int FRAME_BITS  = 32;
  localparam int FRAME_BYTES = FRAME_BITS / 8;
  localparam int MAX_DEGREE  = 19;
  localparam int DEG_W       = 5;
  localparam int CRC_W       = MAX_DEGREE;
  localparam int CFG_W       = CRC_W;
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int POS_W       = 6;
  localparam int VBITS_W     = 6;
  localparam int FNUM_W      = 16;

  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(8);
  localparam logic [CRC_W-1:0] LOW_RESET    = CRC_W'(7);

  // register indexes
  localparam logic REG_GEN_DEGREE    = 1'b0;
  localparam logic REG_GEN_LOW_TERMS = 1'b1;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [POS_W-1:0] flip_position;
  } msg_t;

  typedef struct packed {
    logic [FNUM_W-1:0]     frame_number;
    logic [VBITS_W-1:0]    valid_bits;
    logic [FRAME_BITS-1:0] data_bits;
    logic [CRC_W-1:0]      crc_bits;
    logic                  bit_flipped;
    logic [POS_W-1:0]      flipped_position;
    logic                  last_frame;
  } frame_t;

  // frame on its way through the crc stages
  typedef struct packed {
    logic [FNUM_W-1:0]     frame_number;
    logic [VBITS_W-1:0]    valid_bits;
    logic [FRAME_BITS-1:0] data_bits;
    logic [POS_W-1:0]      flip_position;
    logic                  last_frame;
    logic [CRC_W-1:0]      remainder;
  } stage_t;

  // generator in the form the divider steps use
  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] top_mask;
    logic [CRC_W-1:0] low;
  } gen_t;

  // eight steps of the long division
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] rem_in,
                                                input logic [7:0] byte_in,
                                                input gen_t gen);
    logic [CRC_W-1:0] r;
    logic top;
    r = rem_in;
    for (int i = 7; i >= 0; i--) begin
      top = (|(r & gen.top_mask)) ^ byte_in[i];
      r = (r << 1) & gen.mask;
      if (top) begin
        r = r ^ gen.low;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/crc_framer_with_error_injection.sv
// CRC framer with single-bit error injection.
// msg channel: one message byte per word, sent msb first, with a last marker and
// a flip position that applies to the frame the word completes.
// frame channel: one word per 32-bit frame, carrying data, crc, valid bit count,
// frame number and what was flipped.
// cfg port: cfg_write with cfg_index 0 sets the generator degree, index 1 the
// generator terms below the leading one; write only while the block is idle.
// A byte is taken every cycle while msg_stall is low. The frame word for the byte
// that completes it passes through the crc stages, each of which divides by one
// byte of the frame, and then through the output register.
// Throughput is one byte per cycle unless stalled, one frame per cycle at most.
// Reset clears the open frame, the frame count and the pipeline, and sets the
// generator to degree 8 with terms 7.
// When frame_stall is high the output word holds and the stages fill; once all
// are full msg_stall rises until the output is taken.
module crc_framer_with_error_injection
  import cfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  msg_t             msg,
  output logic             frame_valid,
  input  logic             frame_stall,
  output frame_t           frame,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [DEG_W-1:0] gen_degree;
  logic [CRC_W-1:0] gen_low_terms;
  gen_t             gen;
  logic [DEG_W-1:0] eff_degree;
  logic [CRC_W:0]   wide_mask;

  logic [FRAME_BITS-1:0] pending_bits;
  logic [COUNT_W-1:0]    bytes_in_frame;
  logic [FNUM_W-1:0]     frame_counter;

  logic [FRAME_BITS-1:0] pending_next;
  logic [COUNT_W-1:0]    count_next;
  logic [COUNT_W-1:0]    pad_bytes;
  logic [FNUM_W-1:0]     number_next;
  logic                  emit;
  logic                  accept;

  stage_t stage_word  [FRAME_BYTES+1];
  logic   stage_valid [FRAME_BYTES+1];
  logic   stage_ready [FRAME_BYTES+1];

  frame_t frame_next;
  logic   out_valid;
  frame_t out_word;
  stage_t tail;
  logic [POS_W:0] pos_w;
  logic [POS_W:0] deg_w;
  logic [POS_W:0] data_idx;
  logic [POS_W:0] crc_idx;
  logic           data_hit;
  logic           crc_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_degree    <= DEGREE_RESET;
      gen_low_terms <= LOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GEN_DEGREE:    gen_degree    <= cfg_data[DEG_W-1:0];
        REG_GEN_LOW_TERMS: gen_low_terms <= cfg_data[CRC_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    if (gen_degree == '0) begin
      eff_degree = DEG_W'(1);
    end else if (gen_degree > DEG_W'(MAX_DEGREE)) begin
      eff_degree = DEG_W'(MAX_DEGREE);
    end else begin
      eff_degree = gen_degree;
    end
    wide_mask    = ((CRC_W+1)'(1) << eff_degree) - (CRC_W+1)'(1);
    gen.degree   = eff_degree;
    gen.mask     = wide_mask[CRC_W-1:0];
    gen.top_mask = CRC_W'(1) << (eff_degree - DEG_W'(1));
    gen.low      = gen_low_terms & wide_mask[CRC_W-1:0];
  end

  // frame assembly
  assign pending_next = {pending_bits[FRAME_BITS-9:0], msg.data_byte};
  assign count_next   = bytes_in_frame + COUNT_W'(1);
  assign pad_bytes    = COUNT_W'(FRAME_BYTES) - count_next;
  assign number_next  = frame_counter + FNUM_W'(1);
  assign emit         = (count_next == COUNT_W'(FRAME_BYTES)) || msg.last_byte;

  assign msg_stall = !stage_ready[0];
  assign accept    = msg_valid && !msg_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_frame <= '0;
      frame_counter  <= '0;
    end else if (accept) begin
      if (emit) begin
        bytes_in_frame <= '0;
        frame_counter  <= msg.last_byte ? '0 : number_next;
      end else begin
        bytes_in_frame <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_bits <= pending_next;
    end
  end

  always_comb begin
    stage_valid[0]             = msg_valid && emit;
    stage_word[0].frame_number = number_next;
    stage_word[0].valid_bits   = VBITS_W'({count_next, 3'b000});
    // short frame: shift the bytes up and pad below with zeros
    stage_word[0].data_bits    = pending_next << {pad_bytes, 3'b000};
    stage_word[0].flip_position = msg.flip_position;
    stage_word[0].last_frame   = msg.last_byte;
    stage_word[0].remainder    = '0;
  end

  // one byte of the division per stage
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_stage
    cfb_crc_stage #(
      .STAGE (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .gen      (gen),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_word  (stage_word[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_word  (stage_word[k+1])
    );
  end

  // error injection on the finished codeword
  assign tail     = stage_word[FRAME_BYTES];
  assign pos_w    = {1'b0, tail.flip_position};
  assign deg_w    = (POS_W+1)'(eff_degree);
  assign data_hit = (pos_w != '0) && (pos_w <= (POS_W+1)'(FRAME_BITS));
  assign crc_hit  = (pos_w > (POS_W+1)'(FRAME_BITS))
                    && (pos_w <= (POS_W+1)'(FRAME_BITS) + deg_w);
  assign data_idx = (POS_W+1)'(FRAME_BITS) - pos_w;
  assign crc_idx  = deg_w + (POS_W+1)'(FRAME_BITS) - pos_w;

  always_comb begin
    frame_next.frame_number     = tail.frame_number;
    frame_next.valid_bits       = tail.valid_bits;
    frame_next.data_bits        = tail.data_bits;
    frame_next.crc_bits         = tail.remainder;
    frame_next.bit_flipped      = data_hit || crc_hit;
    frame_next.flipped_position = (data_hit || crc_hit) ? tail.flip_position : '0;
    frame_next.last_frame       = tail.last_frame;
    if (data_hit) begin
      frame_next.data_bits[data_idx[$clog2(FRAME_BITS)-1:0]] =
        !tail.data_bits[data_idx[$clog2(FRAME_BITS)-1:0]];
    end
    if (crc_hit) begin
      frame_next.crc_bits[crc_idx[$clog2(CRC_W)-1:0]] =
        !tail.remainder[crc_idx[$clog2(CRC_W)-1:0]];
    end
  end

  // output register
  assign stage_ready[FRAME_BYTES] = !out_valid || !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready[FRAME_BYTES]) begin
      out_valid <= stage_valid[FRAME_BYTES];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[FRAME_BYTES] && stage_valid[FRAME_BYTES]) begin
      out_word <= frame_next;
    end
  end

  assign frame_valid = out_valid;
  assign frame       = out_word;

endmodule

FILE: design/cfb_crc_stage.sv
module cfb_crc_stage
  import cfb_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  gen_t   gen,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_word,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_word
);

  localparam int BYTE_LSB = FRAME_BITS - 8 * (STAGE + 1);

  logic   valid;
  stage_t word;
  stage_t word_next;

  always_comb begin
    word_next = up_word;
    word_next.remainder = crc_byte(up_word.remainder, up_word.data_bits[BYTE_LSB +: 8], gen);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= word_next;
    end
  end

  assign dn_valid = valid;
  assign dn_word  = word;

endmodule

FILE: design/cfb_checker.sv
`include "crc_framer_with_error_injection_assert.svh"

module cfb_checker
  import cfb_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   frame_valid,
  input logic   frame_stall,
  input frame_t frame
);

  logic vbits_ok;

  // frames are whole bytes, never empty, never over length
  assign vbits_ok = (frame.valid_bits[2:0] == 3'b000) && (frame.valid_bits != '0)
                    && (frame.valid_bits <= VBITS_W'(FRAME_BITS));

  // a stalled word stays put
  `CFB_ASSERT_NEXT(a_frame_hold, frame_valid && frame_stall, frame_valid && $stable(frame))

  `CFB_ASSERT_NOW(a_valid_bits, frame_valid, vbits_ok)

  // the flip flag and the reported position agree
  `CFB_ASSERT_NOW(a_flip_flag, frame_valid, frame.bit_flipped == (frame.flipped_position != '0))

  // nothing comes out straight after reset
  `CFB_ASSERT_NOW(a_reset_empty, $past(rst), !frame_valid)

endmodule

bind crc_framer_with_error_injection cfb_checker u_cfb_checker (.*);

FILE: tb/crc_frame_checker.sv
`timescale 1ns / 100ps

module crc_frame_checker
  import cfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  input  logic             msg_stall,
  input  msg_t             msg,
  input  logic             frame_valid,
  input  logic             frame_stall,
  input  frame_t           frame,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               outstanding
);

  logic [DEG_W-1:0]      gen_degree = DEGREE_RESET;
  logic [CRC_W-1:0]      gen_terms  = LOW_RESET;
  logic [FRAME_BITS-1:0] open_word  = '0;
  int unsigned           open_count = 0;
  logic [FNUM_W-1:0]     frame_count = '0;
  frame_t                frames_due[$];
  int                    fault_count = 0;
  int                    due_count   = 0;

  assign errors      = fault_count;
  assign outstanding = due_count;

  task automatic report_error(input string what);
    if (fault_count < 40) begin
      $display("%0t ns: %s", $time, what);
    end
    fault_count++;
  endtask

  task automatic check_field(input string name, input logic [FRAME_BITS-1:0] got,
                             input logic [FRAME_BITS-1:0] want);
    if (got !== want) begin
      report_error($sformatf("frame field %s: got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  // bit-serial division of the frame followed by deg zero bits
  function automatic logic [CRC_W-1:0] long_divide(input logic [FRAME_BITS-1:0] word,
                                                   input int unsigned deg,
                                                   input logic [CRC_W-1:0] terms);
    logic [CRC_W-1:0] keep;
    logic [CRC_W-1:0] rem;
    logic             fb;
    keep = CRC_W'((64'd1 << deg) - 64'd1);
    rem  = '0;
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      fb  = rem[deg-1] ^ word[i];
      rem = (rem << 1) & keep;
      if (fb) begin
        rem = rem ^ (terms & keep);
      end
    end
    return rem;
  endfunction

  task automatic take_byte(input msg_t m);
    frame_t                f;
    logic [FRAME_BITS-1:0] word;
    int unsigned           deg;
    int unsigned           nbytes;
    int unsigned           p;
    logic                  flipped;
    open_word  = {open_word[FRAME_BITS-9:0], m.data_byte};
    open_count = open_count + 1;
    if (open_count < FRAME_BYTES && !m.last_byte) begin
      return;
    end
    nbytes = open_count;
    if (gen_degree == 0) begin
      deg = 1;
    end else if (gen_degree > MAX_DEGREE) begin
      deg = MAX_DEGREE;
    end else begin
      deg = gen_degree;
    end
    // short final frame is left aligned and zero padded
    word = open_word << (8 * (FRAME_BYTES - nbytes));
    f = '0;
    f.data_bits = word;
    f.crc_bits  = long_divide(word, deg, gen_terms);
    p = m.flip_position;
    flipped = 1'b0;
    if (p >= 1 && p <= FRAME_BITS) begin
      f.data_bits = f.data_bits ^ (FRAME_BITS'(1) << (FRAME_BITS - p));
      flipped = 1'b1;
    end else if (p > FRAME_BITS && p <= FRAME_BITS + deg) begin
      // first crc position is the crc msb
      f.crc_bits = f.crc_bits ^ (CRC_W'(1) << (deg - 1 - (p - FRAME_BITS - 1)));
      flipped = 1'b1;
    end
    f.frame_number     = frame_count + 1'b1;
    f.valid_bits       = VBITS_W'(nbytes * 8);
    f.bit_flipped      = flipped;
    f.flipped_position = flipped ? m.flip_position : '0;
    f.last_frame       = m.last_byte;
    frames_due.push_back(f);
    open_word   = '0;
    open_count  = 0;
    frame_count = m.last_byte ? '0 : frame_count + 1'b1;
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      gen_degree  = DEGREE_RESET;
      gen_terms   = LOW_RESET;
      open_word   = '0;
      open_count  = 0;
      frame_count = '0;
      frames_due.delete();
    end else begin
      if (frame_valid && !frame_stall) begin
        if (frames_due.size() == 0) begin
          report_error($sformatf("unexpected frame word, frame number %0d",
                                 frame.frame_number));
        end else begin
          want = frames_due.pop_front();
          check_field("frame_number", frame.frame_number, want.frame_number);
          check_field("valid_bits", frame.valid_bits, want.valid_bits);
          check_field("data_bits", frame.data_bits, want.data_bits);
          check_field("crc_bits", frame.crc_bits, want.crc_bits);
          check_field("bit_flipped", frame.bit_flipped, want.bit_flipped);
          check_field("flipped_position", frame.flipped_position, want.flipped_position);
          check_field("last_frame", frame.last_frame, want.last_frame);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_GEN_DEGREE: begin
            gen_degree = cfg_data[DEG_W-1:0];
          end
          REG_GEN_LOW_TERMS: begin
            gen_terms = cfg_data[CRC_W-1:0];
          end
        endcase
      end
      if (msg_valid && !msg_stall) begin
        take_byte(msg);
      end
    end
    due_count <= frames_due.size();
  end

endmodule

FILE: tb/tb_crc_framer_with_error_injection.sv
`timescale 1ns / 100ps

module tb_crc_framer_with_error_injection;
  import cfb_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             msg_valid = 1'b0;
  logic             msg_stall;
  msg_t             msg = '0;
  logic             frame_valid;
  logic             frame_stall = 1'b0;
  frame_t           frame;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_GEN_DEGREE;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors;
  int outstanding;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int eff_deg    = 8;

  crc_framer_with_error_injection i_dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg         (msg),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  crc_frame_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg         (msg),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      frame_stall <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      frame_stall <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      frame_stall <= 1'b1;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      frame_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= '{data_byte: b, last_byte: fin, flip_position: pos};
    @(posedge clk);
    while (msg_stall) @(posedge clk);
  endtask

  // hold the sender until every frame word has been taken
  task automatic settle();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_flip();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return '0;
    end else if (r < 7) begin
      return POS_W'($urandom_range(1, FRAME_BITS));
    end else if (r < 9) begin
      return POS_W'($urandom_range(FRAME_BITS + 1, FRAME_BITS + eff_deg));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic send_message(output int len);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      len = $urandom_range(1, 4);
    end else if (r < 9) begin
      len = $urandom_range(5, 12);
    end else begin
      len = $urandom_range(13, 24);
    end
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1, pick_flip());
    end
  endtask

  task automatic set_generator(input logic [DEG_W-1:0] deg, input logic [CRC_W-1:0] terms);
    logic [CFG_W-1:0] val;
    settle();
    // bits above the degree field carry noise
    val = CFG_W'($urandom);
    val[DEG_W-1:0] = deg;
    write_reg(REG_GEN_DEGREE, val);
    write_reg(REG_GEN_LOW_TERMS, terms);
    eff_deg = (deg == 0) ? 1 : ((deg > MAX_DEGREE) ? MAX_DEGREE : int'(deg));
  endtask

  task automatic random_messages(input int nbytes);
    int sent;
    int len;
    sent = 0;
    while (sent < nbytes) begin
      send_message(len);
      sent = sent + len;
    end
  endtask

  task automatic random_idling();
    int pick[3] = '{0, 10, 30};
    gap_pct   = pick[$urandom_range(0, 2)];
    stall_pct = pick[$urandom_range(0, 2)];
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset generator
    send_byte(8'h00, 1'b1, 6'd0);
    send_byte(8'hFF, 1'b1, 6'd1);
    send_byte(8'h80, 1'b0, 6'd5);
    send_byte(8'h01, 1'b0, 6'd0);
    send_byte(8'hFF, 1'b0, 6'd17);
    send_byte(8'h00, 1'b1, 6'd32);
    send_byte(8'h5A, 1'b0, 6'd0);
    send_byte(8'hA5, 1'b0, 6'd0);
    send_byte(8'h3C, 1'b0, 6'd0);
    send_byte(8'hC3, 1'b0, 6'd33);
    send_byte(8'h7E, 1'b1, 6'd40);
    send_byte(8'h5A, 1'b1, 6'd41);
    send_byte(8'hC3, 1'b1, 6'd63);
    send_byte(8'h12, 1'b0, 6'd0);
    send_byte(8'h34, 1'b1, 6'd16);
    send_byte(8'hAB, 1'b0, 6'd0);
    send_byte(8'hCD, 1'b0, 6'd0);
    send_byte(8'hEF, 1'b1, 6'd24);

    set_generator(5'd19, 19'h7FFFF);
    // last crc bit at the widest degree, then one past it
    send_byte(8'hA5, 1'b1, 6'd51);
    send_byte(8'h96, 1'b1, 6'd52);
    random_idling();
    random_messages(48);

    set_generator(5'd1, 19'h00000);
    random_idling();
    random_messages(48);

    set_generator(5'd0, 19'($urandom));
    random_idling();
    random_messages(48);

    set_generator(5'd31, 19'($urandom));
    random_idling();
    random_messages(48);

    set_generator(5'd20, 19'h40001);
    random_idling();
    random_messages(48);

    set_generator(5'd16, 19'h01021);
    gap_pct   = 30;
    stall_pct = 30;
    random_messages(48);

    set_generator(5'($urandom), 19'($urandom));
    random_idling();
    random_messages(48);

    set_generator(5'd5, 19'h00005);
    random_idling();
    random_messages(48);

    set_generator(5'd12, 19'($urandom));
    random_idling();
    random_messages(48);

    // closing stretch at full rate
    set_generator(DEGREE_RESET, LOW_RESET);
    gap_pct   = 0;
    stall_pct = 0;
    random_messages(48);

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("crc_framer_with_error_injection: match");
    end else begin
      $display("crc_framer_with_error_injection: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("crc_framer_with_error_injection: mismatch");
    $finish;
  end

endmodule
